// File: design/sps_pkg.sv
// ----------------------------------------------------------------------------
// Stepper pulse sequencer package
// Shared types, codes and widths of the stepper pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned CountWidthDef = 24;

  localparam int unsigned MoveW     = 24;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned QueuedW   = 5;
  localparam int unsigned QueuedMax = 31;
  localparam int unsigned HalfPeriodRst = 5000;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_e;

endpackage

// File: design/sps_front.sv
// ----------------------------------------------------------------------------
// Stepper pulse sequencer front end
// Accepts input items, classifies them and clamps move fields to the counters.
// ----------------------------------------------------------------------------
module sps_front import sps_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [InDataW-1:0]       s_axis_tdata_i,  // move_steps, move_half_period
  input  logic                     s_axis_tuser_i,  // operation
  input  logic                     q_ready_i,
  output logic                     q_valid_o,
  output logic [2*COUNT_WIDTH:0]   q_item_o
);

  localparam logic signed [32:0] SMax = (33'sd1 <<< (COUNT_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] SMin = -SMax - 33'sd1;
  localparam logic [32:0]        UMax = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic signed [32:0] steps_ext;
  logic        [32:0] hp_ext;
  logic signed [32:0] steps_sat;
  logic        [32:0] hp_sat;
  op_e                op;

  always_comb begin
    steps_ext = 33'(signed'(s_axis_tdata_i[MoveW-1:0]));
    hp_ext    = 33'(s_axis_tdata_i[InDataW-1:MoveW]);
    if (steps_ext > SMax) begin
      steps_sat = SMax;
    end else if (steps_ext < SMin) begin
      steps_sat = SMin;
    end else begin
      steps_sat = steps_ext;
    end
    hp_sat = (hp_ext > UMax) ? UMax : hp_ext;
    op     = op_e'(s_axis_tuser_i);
  end

  assign s_axis_tready_o = q_ready_i;
  assign q_valid_o       = s_axis_tvalid_i;
  assign q_item_o        = {hp_sat[COUNT_WIDTH-1:0], steps_sat[COUNT_WIDTH-1:0], op};

endmodule

// File: design/sps_fifo.sv
// ----------------------------------------------------------------------------
// Stepper pulse sequencer item queue
// Two-entry queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module sps_fifo import sps_pkg::*; #(
  parameter int unsigned WIDTH = 2 * CountWidthDef + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/sps_back.sv
// ----------------------------------------------------------------------------
// Stepper pulse sequencer execution unit
// Holds the move queue and the step timing state and produces the result items.
// ----------------------------------------------------------------------------
module sps_back import sps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  logic [2*COUNT_WIDTH:0]  q_item_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OutDataW-1:0]     m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam logic [CW-1:0]   UMax  = {CW{1'b1}};
  localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);
  localparam logic [CW-1:0]   HpRst = (HalfPeriodRst > (2 ** CW - 1)) ? UMax
                                                                       : CW'(HalfPeriodRst);

  logic signed [CW-1:0] mem_steps [QUEUE_DEPTH];
  logic        [CW-1:0] mem_hp    [QUEUE_DEPTH];

  logic [PtrW-1:0]      head_q, head_d;
  logic [CntW-1:0]      count_q, count_d;
  logic signed [CW-1:0] rem_q, rem_d;
  logic [CW-1:0]        hp_q, hp_d;
  logic [CW-1:0]        elapsed_q, elapsed_d;
  logic                 step_q, step_d;
  logic                 dir_q, dir_d;
  logic signed [CW-1:0] hd_steps_q;
  logic [CW-1:0]        hd_hp_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q, out_data_d;

  op_e                  op;
  logic signed [CW-1:0] in_steps;
  logic [CW-1:0]        in_hp;
  logic                 go, push, tick, full, wr_en, dropped, done, fire;
  logic [PtrW-1:0]      head_nx, tail;
  logic [CntW:0]        tail_sum;
  logic signed [CW-1:0] rem_l;
  logic [CW-1:0]        hp_l, el_inc;
  logic [QueuedW-1:0]   queued;

  assign op       = op_e'(q_item_i[0]);
  assign in_steps = q_item_i[CW:1];
  assign in_hp    = q_item_i[2*CW:CW+1];

  assign q_ready_o = !out_valid_q || m_axis_tready_i;
  assign go        = q_valid_i && q_ready_o;
  assign push      = go && (op == OP_PUSH);
  assign tick      = go && (op == OP_TICK);
  assign full      = (count_q == Depth);
  assign wr_en     = push && !full;

  always_comb begin
    tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
    if (tail_sum >= (CntW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CntW + 1)'(QUEUE_DEPTH);
    end
    tail    = PtrW'(tail_sum);
    head_nx = (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + PtrW'(1);
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    rem_d     = rem_q;
    hp_d      = hp_q;
    elapsed_d = elapsed_q;
    step_d    = step_q;
    dir_d     = dir_q;
    dropped   = 1'b0;
    done      = 1'b0;
    fire      = 1'b0;
    rem_l     = rem_q;
    hp_l      = hp_q;
    el_inc    = (elapsed_q == UMax) ? elapsed_q : elapsed_q + CW'(1);
    if (push) begin
      if (full) begin
        dropped = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (tick) begin
      if ((rem_q == '0) && (count_q != '0)) begin
        rem_l = hd_steps_q;
        hp_l  = hd_hp_q;
      end
      hp_d  = hp_l;
      rem_d = rem_l;
      fire  = (el_inc >= hp_l);
      elapsed_d = fire ? '0 : el_inc;
      if (fire) begin
        if (step_q) begin
          step_d = 1'b0;
        end else if (rem_l != '0) begin
          step_d = 1'b1;
          dir_d  = rem_l[CW-1];
          rem_d  = rem_l[CW-1] ? rem_l + CW'(1) : rem_l - CW'(1);
        end
      end
      if ((rem_d == '0) && (count_q != '0)) begin
        done    = 1'b1;
        head_d  = head_nx;
        count_d = count_q - CntW'(1);
      end
    end
    queued     = (32'(count_d) > QueuedMax) ? QueuedW'(QueuedMax) : QueuedW'(count_d);
    out_data_d = OutDataW'({done, dropped, queued, (rem_d != '0), dir_d, step_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      hp_q        <= HpRst;
      elapsed_q   <= UMax;
      step_q      <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      hp_q      <= hp_d;
      elapsed_q <= elapsed_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The head registers always mirror the queue entry at the head pointer.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_steps[tail] <= in_steps;
      mem_hp[tail]    <= in_hp;
    end
    if (wr_en && (count_q == '0)) begin
      hd_steps_q <= in_steps;
      hd_hp_q    <= in_hp;
    end else if (done) begin
      hd_steps_q <= mem_steps[head_nx];
      hd_hp_q    <= mem_hp[head_nx];
    end
    if (go) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: design/stepper_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper pulse sequencer
// One step/direction channel that queues moves and times step pulses on ticks.
// An item taken passes through the two-entry queue and the back end's output
// register; its result item can then be taken. Throughput: one item per cycle,
// set by the back end, while m_axis_tready_i does not stall the result.
// Reset: asynchronous; queue empty, half period 5000 ticks, first tick fires.
// ----------------------------------------------------------------------------
module stepper_pulse_sequencer import sps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // move_steps, move_half_period
  input  logic                s_axis_tuser_i,  // operation
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // step_level, dir_level, busy_res,
                                               // queued_moves, push_dropped, move_done
);

  localparam int unsigned ItemW = 2 * COUNT_WIDTH + 1;

  logic             f_valid, f_ready;
  logic [ItemW-1:0] f_item;
  logic             b_valid, b_ready;
  logic [ItemW-1:0] b_item;

  sps_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_ready_i      (f_ready),
    .q_valid_o      (f_valid),
    .q_item_o       (f_item)
  );

  sps_fifo #(
    .WIDTH(ItemW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_item),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_item)
  );

  sps_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (b_valid),
    .q_ready_o      (b_ready),
    .q_item_i       (b_item),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule
